// File: hdl/nis_pkg.sv
// Shared types and constants for the Newton reciprocal square root block.
package nis_pkg;

  localparam int unsigned FRAC_BITS = 24;
  localparam logic [31:0] Q_ONE     = 32'h0100_0000;

  localparam logic [1:0] REG_INITIAL_GUESS   = 2'd0;
  localparam logic [1:0] REG_ERROR_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_MAX_ITERATIONS  = 2'd2;

  localparam logic [31:0] RESET_GUESS     = 32'h0100_0000;
  localparam logic [24:0] RESET_THRESHOLD = 25'd168;
  localparam logic [7:0]  RESET_MAX_ITER  = 8'd64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_EX,
    ST_CHK,
    ST_XG,
    ST_TG1,
    ST_TG2,
    ST_UPD,
    ST_FIN
  } nis_state_t;

  // multiplier operand pairs
  typedef enum logic [1:0] {
    MUL_GG,
    MUL_TX,
    MUL_XG,
    MUL_TG
  } mul_op_t;

  typedef struct packed {
    logic    load_item;
    logic    mul_en;
    mul_op_t mul_op;
    logic    chk;
    logic    upd_g;
    logic    load_out;
  } nis_cmd_t;

  typedef struct packed {
    logic err_ok;
    logic cap_hit;
    logic out_full;
  } nis_status_t;

endpackage

// File: hdl/nis_ctrl.sv
// Sequencer for the Newton iteration: steps one item through the shared multiplier.
module nis_ctrl import nis_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  nis_status_t status,
  output nis_cmd_t    cmd
);

  nis_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SQ;
      ST_SQ:   state_next = ST_EX;
      ST_EX:   state_next = ST_CHK;
      ST_CHK: begin
        if (status.err_ok || status.cap_hit) state_next = ST_FIN;
        else state_next = ST_XG;
      end
      ST_XG:   state_next = ST_TG1;
      ST_TG1:  state_next = ST_TG2;
      ST_TG2:  state_next = ST_UPD;
      ST_UPD:  state_next = ST_SQ;
      ST_FIN:  if (!status.out_full) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.mul_op    = MUL_GG;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_SQ: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_GG;
      end
      ST_EX: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_TX;
      end
      ST_CHK: cmd.chk = 1'b1;
      ST_XG: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_XG;
      end
      ST_TG1, ST_TG2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_TG;
      end
      ST_UPD: cmd.upd_g = 1'b1;
      ST_FIN: begin
        cmd.mul_op   = MUL_XG;
        cmd.load_out = !status.out_full;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/nis_datapath.sv
// Datapath: config registers, guess and scratch registers, shared Q8.24 multiplier, result register.
module nis_datapath import nis_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [31:0] x_in,
  input  logic        last_in,
  input  nis_cmd_t    cmd,
  output nis_status_t status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_root,
  output logic        out_conv,
  output logic [7:0]  out_steps,
  output logic        out_last
);

  logic [31:0] initial_guess;
  logic [24:0] error_threshold;
  logic [7:0]  max_iterations;

  logic [31:0] x, g, tmp;
  logic [7:0]  steps;
  logic        last, conv;

  logic [31:0] mul_a, mul_b, mul_q;
  logic [63:0] prod;
  logic [31:0] err;
  logic [33:0] s3g, diff;
  logic [31:0] g_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_guess   <= RESET_GUESS;
      error_threshold <= RESET_THRESHOLD;
      max_iterations  <= RESET_MAX_ITER;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INITIAL_GUESS:   initial_guess   <= cfg_data;
        REG_ERROR_THRESHOLD: error_threshold <= cfg_data[24:0];
        REG_MAX_ITERATIONS:  max_iterations  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.mul_op)
      MUL_GG:  begin mul_a = g;   mul_b = g; end
      MUL_TX:  begin mul_a = tmp; mul_b = x; end
      MUL_XG:  begin mul_a = x;   mul_b = g; end
      default: begin mul_a = tmp; mul_b = g; end
    endcase
  end

  assign prod  = {32'd0, mul_a} * {32'd0, mul_b};
  // saturate when the shifted product spills past 32 bits
  assign mul_q = (|prod[63:56]) ? 32'hFFFF_FFFF : prod[55:24];

  assign err = (tmp >= Q_ONE) ? (tmp - Q_ONE) : (Q_ONE - tmp);

  assign s3g  = {2'b00, g} + {1'b0, g, 1'b0};
  assign diff = s3g - {2'b00, tmp};
  always_comb begin
    if ({2'b00, tmp} >= s3g) g_new = '0;
    else if (diff[33]) g_new = 32'hFFFF_FFFF;
    else g_new = diff[32:1];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      x     <= x_in;
      last  <= last_in;
      g     <= initial_guess;
      steps <= '0;
    end
    if (cmd.mul_en) tmp <= mul_q;
    if (cmd.chk) conv <= status.err_ok;
    if (cmd.upd_g) begin
      g     <= g_new;
      steps <= steps + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_root  <= mul_q;
      out_conv  <= conv;
      out_steps <= steps;
      out_last  <= last;
    end
  end

  assign status.err_ok   = err <= {7'd0, error_threshold};
  assign status.cap_hit  = steps >= max_iterations;
  assign status.out_full = out_valid && !out_ready;

endmodule

// File: hdl/newton_inverse_sqrt_root.sv
// Top level of the Newton-Raphson reciprocal square root block.
//
//  channel  | direction | handshake              | contents
//  s_axis   | in        | s_axis_tvalid/tready   | x_value, last_in on tlast
//  m_axis   | out       | m_axis_tvalid/tready   | root, steps_used, converged on tuser
//  cfg      | in        | cfg_valid/cfg_ready    | register index and write data
//
// An item is taken in the idle state. Each Newton step runs the states SQ, EX, CHK, XG,
// TG1, TG2 and UPD; after the last step SQ, EX and CHK lead to FIN, which loads the result
// register. Each Newton step is five passes through the single 32x32 multiplier plus a check
// and an update; the block takes no new request until it is back at idle.
// Synchronous active-high reset restores the register defaults; no clearing pass.
// A result waiting on m_axis stalls the block only at its end, after the next item ran.
// cfg_ready is always high.
module newton_inverse_sqrt_root import nis_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] x_value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] root, [39:32] steps_used
  output logic        m_axis_tuser,   // [0] converged
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  nis_cmd_t    cmd;
  nis_status_t status;

  assign cfg_ready = 1'b1;

  nis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  nis_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .x_in      (s_axis_tdata),
    .last_in   (s_axis_tlast),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_root  (m_axis_tdata[31:0]),
    .out_conv  (m_axis_tuser),
    .out_steps (m_axis_tdata[39:32]),
    .out_last  (m_axis_tlast)
  );

  // one item in flight: a request blocks the next one
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in progress");

  // a result is loaded only at the end of an item, never while idle
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without an item in progress");

  // after the result is loaded the sequencer is back at idle
  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("sequencer not idle after delivering a result");

endmodule

// File: verif/newton_inverse_sqrt_root_tb.sv
// Self-checking testbench for the Newton reciprocal square root block.
module newton_inverse_sqrt_root_tb import nis_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  REG_UNUSED    = 2'd3;
  localparam int unsigned RUN_LIMIT     = 10_000_000;
  localparam int unsigned LONG_HOLD     = 3000;
  localparam int unsigned SETTLE_CYCLES = 32;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

  typedef struct {
    logic [31:0] root;
    logic        converged;
    logic [7:0]  steps;
    logic        last;
  } root_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // local copy of the register file
  logic [31:0] guess_reg  = RESET_GUESS;
  logic [24:0] thresh_reg = RESET_THRESHOLD;
  logic [7:0]  cap_reg    = RESET_MAX_ITER;

  root_result_t pending_roots[$];
  int unsigned  mismatches   = 0;
  int unsigned  cycle_count  = 0;
  int unsigned  burst_left   = 0;
  logic         offering     = 1'b0;
  int unsigned  hold_request = 0;
  int unsigned  hold_left    = 0;
  int unsigned  mode_left    = 0;
  rx_mode_t     rx_mode      = RX_OPEN;
  logic [31:0]  rx_pattern   = '1;

  newton_inverse_sqrt_root uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Q8.24 product, truncated, saturating
  function automatic logic [31:0] q_mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = ({32'd0, a} * {32'd0, b}) >> FRAC_BITS;
    return (p[63:32] != 0) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  function automatic logic [31:0] rsq_error(input logic [31:0] g, input logic [31:0] x);
    logic [31:0] p;
    p = q_mul(q_mul(g, g), x);
    return (p >= Q_ONE) ? p - Q_ONE : Q_ONE - p;
  endfunction

  function automatic logic [31:0] newton_step(input logic [31:0] g, input logic [31:0] x);
    logic [33:0] t, s, n;
    t = {2'b00, q_mul(q_mul(q_mul(x, g), g), g)};
    s = {2'b00, g} * 34'd3;
    if (t >= s) return '0;
    n = (s - t) >> 1;
    return (n[33:32] != 0) ? 32'hFFFF_FFFF : n[31:0];
  endfunction

  function automatic root_result_t predict_root(input logic [31:0] x, input logic last);
    root_result_t r;
    logic [31:0]  g, err;
    logic [7:0]   steps;
    g = guess_reg;
    steps = '0;
    err = rsq_error(g, x);
    while (err > {7'd0, thresh_reg} && steps < cap_reg) begin
      g = newton_step(g, x);
      steps++;
      err = rsq_error(g, x);
    end
    r.root = q_mul(x, g);
    r.converged = (err <= {7'd0, thresh_reg});
    r.steps = steps;
    r.last = last;
    return r;
  endfunction

  // mostly operands the current guess can converge on, the rest spread over all magnitudes
  function automatic logic [31:0] pick_x();
    logic [127:0] lim;
    logic [31:0]  top;
    int unsigned  sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      if (guess_reg == 0) begin
        top = 32'hFFFF_FFFF;
      end else begin
        lim = (128'd3 << 72) / ({96'd0, guess_reg} * {96'd0, guess_reg});
        top = (lim > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : lim[31:0];
      end
      if (top == 0) top = 1;
      return $urandom_range(0, top);
    end else if (sel < 8) begin
      return $urandom >> $urandom_range(0, 31);
    end
    return $urandom;
  endfunction

  task automatic send_item(input logic [31:0] x, input logic last);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    s_axis_tlast  <= last;
    offering = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_roots.push_back(predict_root(x, last));
    burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic pause_sender();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
    burst_left = 0;
  endtask

  task automatic drain_results();
    pause_sender();
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_INITIAL_GUESS:   guess_reg = data;
      REG_ERROR_THRESHOLD: thresh_reg = data[24:0];
      REG_MAX_ITERATIONS:  cap_reg = data[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] g, input logic [31:0] thr, input logic [7:0] cap);
    drain_results();
    write_reg(REG_INITIAL_GUESS, g);
    write_reg(REG_ERROR_THRESHOLD, thr);
    write_reg(REG_MAX_ITERATIONS, {24'd0, cap});
  endtask

  task automatic test_directed_extremes();
    logic [31:0] probes [0:7];
    probes = '{32'h0000_0000, 32'hFFFF_FFFF, Q_ONE, 32'h0000_0001,
               32'h0400_0000, 32'h0040_0000, 32'h8000_0000, 32'h0200_0000};
    foreach (probes[i]) send_item(probes[i], i[0]);
    drain_results();
  endtask

  task automatic test_special_cases();
    // no steps allowed
    configure(Q_ONE, {7'd0, RESET_THRESHOLD}, 8'd0);
    send_item(32'h0200_0000, 1'b0);
    send_item(32'h0080_0000, 1'b1);
    // zero guess never moves
    configure(32'h0000_0000, 32'd168, 8'd5);
    send_item(Q_ONE, 1'b0);
    send_item(32'h0300_0000, 1'b1);
    // threshold of 1.0 accepts a zero operand at once
    configure(Q_ONE, 32'h0100_0000, 8'd10);
    send_item(32'h0000_0000, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b0);
    // largest guess, exact convergence demanded, longest cap
    configure(32'hFFFF_FFFF, 32'd0, 8'd255);
    send_item(Q_ONE, 1'b0);
    send_item(32'h0000_0001, 1'b1);
    // unknown register index leaves the setting alone
    drain_results();
    write_reg(REG_UNUSED, 32'h0000_0000);
    send_item(32'h0200_0000, 1'b1);
    send_item(32'h0000_0000, 1'b0);
    drain_results();
  endtask

  task automatic test_backpressure();
    configure(Q_ONE, {7'd0, RESET_THRESHOLD}, 8'd16);
    hold_request = LONG_HOLD;
    burst_left = 40;
    repeat (12) send_item(pick_x(), $urandom_range(0, 3) == 0);
    drain_results();
  endtask

  task automatic test_random_default();
    configure(RESET_GUESS, {7'd0, RESET_THRESHOLD}, RESET_MAX_ITER);
    repeat (220) send_item(pick_x(), $urandom_range(0, 3) == 0);
    drain_results();
  endtask

  task automatic test_random_configs();
    logic [31:0] g, thr;
    logic [7:0]  cap;
    repeat (6) begin
      case ($urandom_range(0, 5))
        4:       g = $urandom;
        5:       g = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        default: g = (Q_ONE << 1) >> $urandom_range(0, 7);
      endcase
      case ($urandom_range(0, 9))
        0:       thr = 32'd0;
        1:       thr = 32'h0100_0000;
        default: thr = $urandom_range(1, 4096);
      endcase
      cap = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(1, 40));
      configure(g, thr, cap);
      repeat (45) send_item(pick_x(), $urandom_range(0, 3) == 0);
    end
    drain_results();
  endtask

  task automatic test_long_cap();
    configure(Q_ONE, 32'd0, 8'd255);
    send_item(32'h0000_0000, 1'b1);
    repeat (7) send_item(pick_x(), $urandom_range(0, 1));
    drain_results();
  endtask

  // receiver: random ready patterns, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_pattern = $urandom;
      mode_left = $urandom_range(20, 120);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
        default: begin
          m_axis_tready <= rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[31:1]};
        end
      endcase
    end
  end

  always @(posedge clk) begin
    root_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual root %h steps %0d",
                 $time, m_axis_tdata[31:0], m_axis_tdata[39:32]);
        mismatches++;
      end else begin
        want = pending_roots.pop_front();
        if (m_axis_tdata[31:0] !== want.root) begin
          $display("%0t: root: expected %h, actual %h", $time, want.root, m_axis_tdata[31:0]);
          mismatches++;
        end
        if (m_axis_tdata[39:32] !== want.steps) begin
          $display("%0t: steps_used: expected %0d, actual %0d",
                   $time, want.steps, m_axis_tdata[39:32]);
          mismatches++;
        end
        if (m_axis_tuser !== want.converged) begin
          $display("%0t: converged: expected %b, actual %b", $time, want.converged, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last_out: expected %b, actual %b", $time, want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("newton_inverse_sqrt_root: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_special_cases();
    test_backpressure();
    test_random_default();
    test_random_configs();
    test_long_cap();
    drain_results();
    if (mismatches == 0) begin
      $display("newton_inverse_sqrt_root: match");
    end else begin
      $display("newton_inverse_sqrt_root: mismatch");
    end
    $finish;
  end

endmodule
